/* rtl/tcbr_pkg.sv */
// Package for the two-way cache byte read block: payload widths, result codes,
// state type, result item type and small helper functions.
// No dependencies; every other file of the block imports it.
package tcbr_pkg;

    localparam int NUM_SETS_DEF  = 32;
    localparam int ADDR_BITS_DEF = 20;
    localparam int PHYS_ADDR_W   = 31;
    localparam int WORD_W        = 32;
    localparam int BYTE_W        = 8;
    localparam int OFF_W         = 2;
    localparam int SRC_W         = 2;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [SRC_W-1:0] SRC_CACHE = 2'd0;
    localparam logic [SRC_W-1:0] SRC_FILL  = 2'd1;
    localparam logic [SRC_W-1:0] SRC_ERROR = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [SRC_W-1:0]  source;
    } result_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } back_state_t;

    // Tag width: the word address bits above the set index, at least one bit.
    function automatic int tag_w(input int addr_bits, input int num_sets);
        int w;
        begin
            w = addr_bits - OFF_W - $clog2(num_sets);
            tag_w = (w < 1) ? 1 : w;
        end
    endfunction

    // Little-endian byte select within a word.
    function automatic logic [BYTE_W-1:0] pick_byte(input logic [WORD_W-1:0] word,
                                                    input logic [OFF_W-1:0] off);
        logic [BYTE_W-1:0] b;
        begin
            unique case (off)
                2'd0:    b = word[7:0];
                2'd1:    b = word[15:8];
                2'd2:    b = word[23:16];
                default: b = word[31:24];
            endcase
            pick_byte = b;
        end
    endfunction

endpackage

/* rtl/two_way_cache_byte_read.sv */
// Two-way set-associative read cache returning one byte per item; FIFO replacement.
// No command is taken while a lookup waits on the tag store's registered read.
// Reset: asynchronous and active low; the tag store is then cleared one set per cycle,
// through all NUM_SETS sets, and full stays high until the pass is done.
// Depends on tcbr_pkg, tcbr_fifo, tcbr_front and tcbr_back.
module two_way_cache_byte_read #(
    parameter int NUM_SETS  = tcbr_pkg::NUM_SETS_DEF,
    parameter int ADDR_BITS = tcbr_pkg::ADDR_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [tcbr_pkg::PHYS_ADDR_W-1:0] phys_addr,
    input  logic [tcbr_pkg::WORD_W-1:0]      fill_word,
    output logic                             empty,
    input  logic                             pop,
    output logic [tcbr_pkg::BYTE_W-1:0]      data_byte,
    output logic [tcbr_pkg::SRC_W-1:0]       source
);
    import tcbr_pkg::*;

    // NUM_SETS is taken to be a power of two, so the set index is a plain
    // bit field of the word address and the tag is the bits above it.
    localparam int SET_W = $clog2(NUM_SETS);
    localparam int TAG_W = tag_w(ADDR_BITS, NUM_SETS);
    localparam int RES_W = $bits(result_t);

    // Command path from the front part to the back part.
    logic              cmd_pop, cmd_empty, cmd_err;
    logic [OFF_W-1:0]  cmd_off;
    logic [SET_W-1:0]  cmd_set;
    logic [TAG_W-1:0]  cmd_tag;
    logic [WORD_W-1:0] cmd_word;

    // Result path from the back part to the output queue.
    logic              res_push, res_full, clearing;
    result_t           res, res_head;
    logic [RES_W-1:0]  res_head_bits;

    // The front part decodes each item and parks it in a short command queue,
    // so the input side keeps taking items while the back part is busy with
    // a lookup. It holds off input items during the clearing pass.
    tcbr_front #(
        .NUM_SETS  (NUM_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .phys_addr (phys_addr),
        .fill_word (fill_word),
        .hold      (clearing),
        .full      (full),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd_err   (cmd_err),
        .cmd_off   (cmd_off),
        .cmd_set   (cmd_set),
        .cmd_tag   (cmd_tag),
        .cmd_word  (cmd_word)
    );

    // The back part owns the tag and data stores. It takes one command only
    // when the output queue has room, reads the set, then in the following
    // cycle compares both ways at once, refills on a miss and hands over the
    // result. Out-of-range addresses skip the stores entirely.
    tcbr_back #(
        .NUM_SETS  (NUM_SETS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_err   (cmd_err),
        .cmd_off   (cmd_off),
        .cmd_set   (cmd_set),
        .cmd_tag   (cmd_tag),
        .cmd_word  (cmd_word),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res),
        .clearing  (clearing)
    );

    // The output queue separates the two sides: a finished result may wait
    // here for pop while the back part carries on with the next command.
    tcbr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_head_bits),
        .empty (empty)
    );

    assign res_head  = result_t'(res_head_bits);
    assign data_byte = res_head.data_byte;
    assign source    = res_head.source;

endmodule

/* rtl/tcbr_fifo.sv */
// Small register queue with push/full and pop/empty sides.
// Depends on tcbr_pkg for the default depth.
module tcbr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tcbr_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import tcbr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

/* rtl/tcbr_front.sv */
// Front part: takes input items, checks the address range, splits the address
// into offset, set and tag, and queues the decoded command. Uses tcbr_pkg, tcbr_fifo.
module tcbr_front #(
    parameter int NUM_SETS  = tcbr_pkg::NUM_SETS_DEF,
    parameter int ADDR_BITS = tcbr_pkg::ADDR_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              push,
    input  logic [tcbr_pkg::PHYS_ADDR_W-1:0]                  phys_addr,
    input  logic [tcbr_pkg::WORD_W-1:0]                       fill_word,
    input  logic                                              hold,
    output logic                                              full,
    input  logic                                              cmd_pop,
    output logic                                              cmd_empty,
    output logic                                              cmd_err,
    output logic [tcbr_pkg::OFF_W-1:0]                        cmd_off,
    output logic [$clog2(NUM_SETS)-1:0]                       cmd_set,
    output logic [tcbr_pkg::tag_w(ADDR_BITS, NUM_SETS)-1:0]   cmd_tag,
    output logic [tcbr_pkg::WORD_W-1:0]                       cmd_word
);
    import tcbr_pkg::*;

    localparam int SET_W = $clog2(NUM_SETS);
    localparam int TAG_W = tag_w(ADDR_BITS, NUM_SETS);
    localparam int WA_W  = ADDR_BITS - OFF_W;
    localparam int EXT_W = WA_W + SET_W + TAG_W;
    localparam int CMD_W = 1 + OFF_W + SET_W + TAG_W + WORD_W;

    logic             q_full;
    logic             in_err;
    logic [WA_W-1:0]  word_addr;
    logic [EXT_W-1:0] word_addr_ext;
    logic [CMD_W-1:0] q_wdata, q_rdata;

    // Any address bit at or above ADDR_BITS set means the address is out of range.
    assign in_err        = ((phys_addr >> ADDR_BITS) != '0);
    assign word_addr     = phys_addr[ADDR_BITS-1:OFF_W];
    assign word_addr_ext = EXT_W'(word_addr);
    assign q_wdata       = {in_err, phys_addr[OFF_W-1:0], word_addr_ext[SET_W-1:0],
                            word_addr_ext[SET_W +: TAG_W], fill_word};

    assign full = q_full || hold;

    tcbr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && !hold),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (cmd_pop),
        .rdata (q_rdata),
        .empty (cmd_empty)
    );

    assign {cmd_err, cmd_off, cmd_set, cmd_tag, cmd_word} = q_rdata;

endmodule

/* rtl/tcbr_back.sv */
// Back part: clears the tag store after reset, then looks up each in-range command
// in the two ways, fills on a miss and pushes one result per command. Uses tcbr_pkg.
module tcbr_back #(
    parameter int NUM_SETS  = tcbr_pkg::NUM_SETS_DEF,
    parameter int ADDR_BITS = tcbr_pkg::ADDR_BITS_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              cmd_empty,
    output logic                                              cmd_pop,
    input  logic                                              cmd_err,
    input  logic [tcbr_pkg::OFF_W-1:0]                        cmd_off,
    input  logic [$clog2(NUM_SETS)-1:0]                       cmd_set,
    input  logic [tcbr_pkg::tag_w(ADDR_BITS, NUM_SETS)-1:0]   cmd_tag,
    input  logic [tcbr_pkg::WORD_W-1:0]                       cmd_word,
    input  logic                                              res_full,
    output logic                                              res_push,
    output tcbr_pkg::result_t                                 res,
    output logic                                              clearing
);
    import tcbr_pkg::*;

    localparam int SET_W  = $clog2(NUM_SETS);
    localparam int TAG_W  = tag_w(ADDR_BITS, NUM_SETS);
    // Tag store row: newest way, valid 1, valid 0, tag 1, tag 0.
    localparam int V0_B   = 2 * TAG_W;
    localparam int V1_B   = 2 * TAG_W + 1;
    localparam int NEW_B  = 2 * TAG_W + 2;
    localparam int META_W = 2 * TAG_W + 3;

    back_state_t state_reg, state_next;
    logic [SET_W-1:0]  clr_cnt_reg, clr_cnt_next;

    logic [META_W-1:0] meta_mem [NUM_SETS];
    logic [WORD_W-1:0] data0_mem [NUM_SETS];
    logic [WORD_W-1:0] data1_mem [NUM_SETS];

    logic [META_W-1:0] meta_rd_reg;
    logic [WORD_W-1:0] data0_rd_reg, data1_rd_reg;

    logic [OFF_W-1:0]  off_reg;
    logic [SET_W-1:0]  set_reg;
    logic [TAG_W-1:0]  tag_reg;
    logic [WORD_W-1:0] word_reg;

    logic              take, rd_en;
    logic              meta_we, data0_we, data1_we;
    logic [SET_W-1:0]  meta_waddr;
    logic [META_W-1:0] meta_wdata;

    logic              hit0, hit1, victim;
    logic [META_W-1:0] meta_upd;

    assign take     = !cmd_empty && !res_full;
    assign clearing = (state_reg == ST_CLEAR);

    // Hit test and victim choice on the registered row.
    always_comb
    begin
        hit0 = meta_rd_reg[V0_B] && (meta_rd_reg[0 +: TAG_W] == tag_reg);
        hit1 = meta_rd_reg[V1_B] && (meta_rd_reg[TAG_W +: TAG_W] == tag_reg);
        priority if (!meta_rd_reg[V0_B])
        begin
            victim = 1'b0;
        end
        else if (!meta_rd_reg[V1_B])
        begin
            victim = 1'b1;
        end
        else
        begin
            victim = !meta_rd_reg[NEW_B];
        end
        meta_upd        = meta_rd_reg;
        meta_upd[NEW_B] = victim;
        if (victim)
        begin
            meta_upd[TAG_W +: TAG_W] = tag_reg;
            meta_upd[V1_B]           = 1'b1;
        end
        else
        begin
            meta_upd[0 +: TAG_W] = tag_reg;
            meta_upd[V0_B]       = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (take && !cmd_err)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs and store controls.
    always_comb
    begin
        cmd_pop       = 1'b0;
        rd_en         = 1'b0;
        res_push      = 1'b0;
        res.data_byte = '0;
        res.source    = SRC_ERROR;
        meta_we       = 1'b0;
        meta_waddr    = set_reg;
        meta_wdata    = meta_upd;
        data0_we      = 1'b0;
        data1_we      = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                meta_we    = 1'b1;
                meta_waddr = clr_cnt_reg;
                meta_wdata = '0;
            end
            ST_IDLE:
            begin
                cmd_pop  = take;
                rd_en    = take && !cmd_err;
                res_push = take && cmd_err;
            end
            ST_LOOKUP:
            begin
                res_push = 1'b1;
                if (hit0)
                begin
                    res.data_byte = pick_byte(data0_rd_reg, off_reg);
                    res.source    = SRC_CACHE;
                end
                else if (hit1)
                begin
                    res.data_byte = pick_byte(data1_rd_reg, off_reg);
                    res.source    = SRC_CACHE;
                end
                else
                begin
                    res.data_byte = pick_byte(word_reg, off_reg);
                    res.source    = SRC_FILL;
                    meta_we       = 1'b1;
                    data0_we      = !victim;
                    data1_we      = victim;
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            off_reg  <= cmd_off;
            set_reg  <= cmd_set;
            tag_reg  <= cmd_tag;
            word_reg <= cmd_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (rd_en)
        begin
            meta_rd_reg <= meta_mem[cmd_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data0_we)
        begin
            data0_mem[set_reg] <= word_reg;
        end
        if (rd_en)
        begin
            data0_rd_reg <= data0_mem[cmd_set];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data1_we)
        begin
            data1_mem[set_reg] <= word_reg;
        end
        if (rd_en)
        begin
            data1_rd_reg <= data1_mem[cmd_set];
        end
    end

endmodule

/* rtl/tcbr_checker.sv */
// Port-level checks for the two-way cache byte read block, bound to its top level.
// Uses tcbr_pkg for the result codes.
module tcbr_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             full,
    input logic                             empty,
    input logic                             pop,
    input logic [tcbr_pkg::BYTE_W-1:0]      data_byte,
    input logic [tcbr_pkg::SRC_W-1:0]       source
);
    import tcbr_pkg::*;

    // While reset is held nothing is waiting on the output side.
    assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // The block does not take items straight out of reset: it clears its tags first.
    assert property (@(posedge clk) $rose(rst_n) |-> full)
        else $error("item accepted before tag store clear");

    // Only the three defined codes ever appear.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (source == SRC_CACHE || source == SRC_FILL || source == SRC_ERROR))
        else $error("undefined source code");

    // An address error carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && source == SRC_ERROR) |-> (data_byte == '0))
        else $error("error item with non-zero byte");

    // A waiting result holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(data_byte) && $stable(source)))
        else $error("waiting result changed");

endmodule

bind two_way_cache_byte_read tcbr_checker u_tcbr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .full      (full),
    .empty     (empty),
    .pop       (pop),
    .data_byte (data_byte),
    .source    (source)
);

/* tb/two_way_cache_byte_read_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the two-way cache byte read block: directed and random accesses
// go through the push/full queue and results are checked against an in-bench cache mirror.
// Depends on tcbr_pkg and two_way_cache_byte_read.
module two_way_cache_byte_read_tb;
    import tcbr_pkg::*;

    // Geometry of the cache as built with its default parameters. The address is split into a
    // byte offset, a set index and a tag that fills the remaining bits below ADDR_BITS.
    localparam int NUM_SETS    = NUM_SETS_DEF;
    localparam int ADDR_BITS   = ADDR_BITS_DEF;
    localparam int SET_BITS    = $clog2(NUM_SETS);
    localparam int TAG_BITS    = ADDR_BITS - OFF_W - SET_BITS;
    localparam int NUM_LINES   = 2 * NUM_SETS;
    localparam int POOL_TAGS   = 4;
    localparam int STALL_LIMIT = 2000;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [PHYS_ADDR_W-1:0] phys_addr;
    logic [WORD_W-1:0]      fill_word;
    logic                   empty;
    logic                   pop;
    logic [BYTE_W-1:0]      data_byte;
    logic [SRC_W-1:0]       source;

    // Mirror of the cache contents, kept in step with every accepted item. Line (set s, way w)
    // sits at index 2*s+w.
    logic [TAG_BITS-1:0] tag_mirror    [NUM_LINES];
    logic                valid_mirror  [NUM_LINES];
    logic [WORD_W-1:0]   word_mirror   [NUM_LINES];
    logic                newest_mirror [NUM_SETS];

    // Results still owed by the block, oldest first.
    result_t pending_bytes[$];
    result_t oldest_byte;

    int error_count = 0;
    int idle_cycles = 0;
    int pop_gap     = 0;

    // While set, neither the sender nor the receiver leaves any gaps.
    bit steady_flow = 1'b0;

    two_way_cache_byte_read u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .phys_addr (phys_addr),
        .fill_word (fill_word),
        .empty     (empty),
        .pop       (pop),
        .data_byte (data_byte),
        .source    (source)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Gap lengths for both sides: mostly none, often short, now and then a long one.
    function automatic int draw_gap();
        int roll;
        if (steady_flow)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [BYTE_W-1:0] lane_of(input logic [WORD_W-1:0] word,
                                                 input logic [OFF_W-1:0] off);
        return word[8*off +: BYTE_W];
    endfunction

    function automatic logic [PHYS_ADDR_W-1:0] line_addr(input logic [TAG_BITS-1:0] tag,
                                                         input logic [SET_BITS-1:0] set_idx,
                                                         input logic [OFF_W-1:0] off);
        return {{(PHYS_ADDR_W - ADDR_BITS){1'b0}}, tag, set_idx, off};
    endfunction

    task automatic clear_mirror();
        for (int i = 0; i < NUM_LINES; i++)
        begin
            tag_mirror[i]   = '0;
            valid_mirror[i] = 1'b0;
            word_mirror[i]  = '0;
        end
        for (int s = 0; s < NUM_SETS; s++)
            newest_mirror[s] = 1'b0;
    endtask

    // Works out the result of one access and updates the mirror as the cache would.
    // A hit leaves the replacement order alone, so eviction is first in, first out.
    function automatic result_t lookup_byte(input logic [PHYS_ADDR_W-1:0] addr,
                                            input logic [WORD_W-1:0] word);
        result_t             res;
        logic [OFF_W-1:0]    off;
        logic [SET_BITS-1:0] set_idx;
        logic [TAG_BITS-1:0] tag;
        int                  base;
        int                  victim;

        // Anything outside the cacheable range is refused and leaves the state as it was.
        if (addr[PHYS_ADDR_W-1:ADDR_BITS] != '0)
        begin
            res.data_byte = '0;
            res.source    = SRC_ERROR;
            return res;
        end

        off     = addr[OFF_W-1:0];
        set_idx = addr[OFF_W +: SET_BITS];
        tag     = addr[OFF_W + SET_BITS +: TAG_BITS];
        base    = 2 * set_idx;

        // Way 0 is looked at first; only a valid line may hit.
        for (int w = 0; w < 2; w++)
        begin
            if (valid_mirror[base + w] && tag_mirror[base + w] == tag)
            begin
                res.data_byte = lane_of(word_mirror[base + w], off);
                res.source    = SRC_CACHE;
                return res;
            end
        end

        // Miss: an empty way is taken first, otherwise the older of the two is replaced.
        if (!valid_mirror[base])
            victim = 0;
        else if (!valid_mirror[base + 1])
            victim = 1;
        else
            victim = newest_mirror[set_idx] ? 0 : 1;

        tag_mirror[base + victim]   = tag;
        word_mirror[base + victim]  = word;
        valid_mirror[base + victim] = 1'b1;
        newest_mirror[set_idx]      = (victim == 1);

        res.data_byte = lane_of(word, off);
        res.source    = SRC_FILL;
        return res;
    endfunction

    // Every accepted item is predicted at the edge that takes it, and every accepted result is
    // compared with the oldest prediction. The expectation of an item taken at this edge cannot
    // be the result leaving at the same edge, so the order of the two steps does not matter.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            pending_bytes.push_back(lookup_byte(phys_addr, fill_word));
        if (rst_n && pop && !empty)
        begin
            if (pending_bytes.size() == 0)
            begin
                $error("result with nothing expected: data_byte %0h source %0d",
                       data_byte, source);
                error_count++;
            end
            else
            begin
                oldest_byte = pending_bytes.pop_front();
                if (data_byte !== oldest_byte.data_byte)
                begin
                    $error("data_byte: expected %0h, got %0h", oldest_byte.data_byte, data_byte);
                    error_count++;
                end
                if (source !== oldest_byte.source)
                begin
                    $error("source: expected %0d, got %0d", oldest_byte.source, source);
                    error_count++;
                end
            end
        end
    end

    // The receiver takes results with random pauses of its own.
    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else if (pop_gap > 0)
        begin
            pop     <= 1'b0;
            pop_gap <= pop_gap - 1;
        end
        else
        begin
            pop     <= 1'b1;
            pop_gap <= draw_gap();
        end
    end

    // The run is abandoned if nothing moves on either side for too long. The limit covers the
    // clearing pass after reset and the longest pauses of both sides many times over.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("two_way_cache_byte_read verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offers one item, after a random gap, and returns at the edge that accepts it. Push is left
    // high so that back-to-back items need no second assignment in the same time step.
    task automatic send_access(input logic [PHYS_ADDR_W-1:0] addr,
                               input logic [WORD_W-1:0] word);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push      <= 1'b1;
        phys_addr <= addr;
        fill_word <= word;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Holds the sender back until every result owed has been taken. At least one edge passes
    // first, so the prediction for the last accepted item has certainly been queued.
    task automatic wait_for_drain();
        push <= 1'b0;
        do
            @(posedge clk);
        while (pending_bytes.size() != 0);
    endtask

    // Out-of-range addresses, from the first one above the cacheable range to all ones. The
    // access to address zero afterwards must miss, which shows the refused item filled nothing.
    task automatic test_address_errors();
        send_access(31'(1) << ADDR_BITS, 32'h0BAD_F00D);
        send_access('1, 32'hFFFF_FFFF);
        send_access(31'h2AAA_AAAA, 32'hAAAA_AAAA);
        send_access(31'h0, 32'h0000_0000);
        send_access(31'((1 << ADDR_BITS) - 1), 32'h8899_AABB);
    endtask

    // A miss fills way 0 of a set and hits read its remaining byte lanes; a second tag then fills
    // way 1 and is hit once. Each hit has a fill word that differs and so must be ignored.
    task automatic test_fill_and_hit();
        send_access(line_addr(13'h0A5A, 5'd3, 2'd0), 32'h4433_2211);
        send_access(line_addr(13'h0A5A, 5'd3, 2'd1), 32'hDEAD_BEEF);
        send_access(line_addr(13'h0A5A, 5'd3, 2'd2), 32'h0000_0000);
        send_access(line_addr(13'h0A5A, 5'd3, 2'd3), 32'hFFFF_FFFF);
        send_access(line_addr(13'h15A5, 5'd3, 2'd2), 32'h5566_7788);
        send_access(line_addr(13'h15A5, 5'd3, 2'd3), 32'h1234_5678);
    endtask

    // With both ways valid the older fill is replaced, even when it has just been hit.
    task automatic test_fifo_eviction();
        send_access(line_addr(13'h0000, 5'd7, 2'd0), 32'h0101_0101);
        send_access(line_addr(13'h1FFF, 5'd7, 2'd1), 32'h0202_0202);
        send_access(line_addr(13'h0000, 5'd7, 2'd2), 32'hEEEE_EEEE);
        send_access(line_addr(13'h0F0F, 5'd7, 2'd3), 32'h0303_0303);
        send_access(line_addr(13'h1FFF, 5'd7, 2'd0), 32'hEEEE_EEEE);
        send_access(line_addr(13'h0000, 5'd7, 2'd1), 32'h0404_0404);
        send_access(line_addr(13'h0F0F, 5'd7, 2'd2), 32'hEEEE_EEEE);
        send_access(line_addr(13'h0000, 5'd7, 2'd3), 32'hEEEE_EEEE);
        send_access(line_addr(13'h1FFF, 5'd7, 2'd0), 32'h0505_0505);
    endtask

    // Random traffic. Most accesses come from a small pool of tags per phase, so sets see hits,
    // fills and evictions in turn; the rest are scattered addresses and refused ones.
    task automatic test_random_traffic(input int count, input bit no_gaps);
        logic [TAG_BITS-1:0]    tag_pool [POOL_TAGS];
        logic [PHYS_ADDR_W-1:0] addr;
        int                     roll;

        steady_flow = no_gaps;
        for (int i = 0; i < POOL_TAGS; i++)
            tag_pool[i] = TAG_BITS'($urandom());
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                addr = line_addr(tag_pool[$urandom_range(0, POOL_TAGS - 1)],
                                 SET_BITS'($urandom()), OFF_W'($urandom()));
            else if (roll < 95)
                addr = PHYS_ADDR_W'($urandom_range(0, (1 << ADDR_BITS) - 1));
            else
                addr = PHYS_ADDR_W'($urandom_range(1 << ADDR_BITS, 32'h7FFF_FFFF));
            send_access(addr, $urandom());
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        push      = 1'b0;
        phys_addr = '0;
        fill_word = '0;
        clear_mirror();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_address_errors();
        test_fill_and_hit();
        test_fifo_eviction();

        // The random phases alternate between gappy and gap-free flow, and the sender waits for
        // the block to empty completely between them.
        for (int phase = 0; phase < 5; phase++)
        begin
            test_random_traffic(345, phase % 2 == 1);
            wait_for_drain();
        end

        // Everything has been answered; the bench waits on so that any stray result is still caught.
        repeat (8) @(posedge clk);

        if (error_count == 0 && pending_bytes.size() == 0)
            $display("two_way_cache_byte_read verification clean");
        else
            $display("two_way_cache_byte_read verification failed");
        $finish;
    end

endmodule
